[rtl/hwfm_pkg.sv]
// ---------------------------------------------------------------------------
// hwfm_pkg
// Shared widths, accumulator codes and elaboration-time coefficient
// functions for the windowed FFT magnitude block.
// ---------------------------------------------------------------------------
package hwfm_pkg;

	localparam int FFT_N_DEF   = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int WORK_BITS   = SAMPLE_BITS + 7;
	localparam int MUL_W       = WORK_BITS + 1;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int ACC_W       = PROD_W + 1;
	localparam int ROOT_W      = PROD_W / 2;
	localparam int MAG_W       = 22;
	localparam int BIN_W       = 6;
	localparam int WIN_W       = 16;
	localparam int TW_W        = 17;
	localparam int TW_LOG      = 5;

	// accumulator operations of the shared multiply unit
	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;
	localparam logic [1:0] ACC_SUB  = 2'd3;

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	// truncating odd series for sine, angle and result in q30
	function automatic longint unsigned sin_q30(input longint unsigned y);
		longint unsigned y2;
		longint unsigned t;
		y2 = (y * y) >> 30;
		t  = ONE_Q30;
		t  = ONE_Q30 - (((y2 * t) >> 30) / 110);
		t  = ONE_Q30 - (((y2 * t) >> 30) / 72);
		t  = ONE_Q30 - (((y2 * t) >> 30) / 42);
		t  = ONE_Q30 - (((y2 * t) >> 30) / 20);
		t  = ONE_Q30 - (((y2 * t) >> 30) / 6);
		return (y * t) >> 30;
	endfunction

	// hann coefficient: squared sine, rounded to q1.15 and clamped
	function automatic logic [WIN_W-1:0] win_coef(input longint unsigned ang);
		longint unsigned s;
		longint unsigned w;
		s = sin_q30(ang);
		w = (s * s + (64'd1 << 44)) >> 45;
		return (w > 64'd32767) ? WIN_W'(32767) : WIN_W'(w);
	endfunction

	// quarter-wave sine entry in q1.15, 1.0 kept as 32768
	function automatic logic signed [TW_W-1:0] qsin_coef(input longint unsigned ang);
		longint unsigned s;
		s = sin_q30(ang);
		return TW_W'((s + (64'd1 << 14)) >> 15);
	endfunction

endpackage

[rtl/hwfm_mac.sv]
// ---------------------------------------------------------------------------
// hwfm_mac
// Shared signed multiplier with a registered product and an accumulator
// that loads, adds or subtracts the previous product.
// ---------------------------------------------------------------------------
module hwfm_mac import hwfm_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  op_a,
	input  logic signed [MUL_W-1:0]  op_b,
	input  logic [1:0]               acc_op,
	output logic signed [PROD_W-1:0] prod_s1,
	output logic signed [ACC_W-1:0]  acc_q
);

	logic signed [ACC_W-1:0] prod_ext;

	assign prod_ext = ACC_W'(prod_s1);

	// product register
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	// accumulator on the registered product
	always_ff @(posedge clk) begin
		unique case (acc_op)
			ACC_LOAD: acc_q <= prod_ext;
			ACC_ADD:  acc_q <= acc_q + prod_ext;
			ACC_SUB:  acc_q <= acc_q - prod_ext;
			default:  acc_q <= acc_q;
		endcase
	end

endmodule

[rtl/hwfm_isqrt.sv]
// ---------------------------------------------------------------------------
// hwfm_isqrt
// Floor integer square root, one root bit per cycle by the restoring
// digit method.
// ---------------------------------------------------------------------------
module hwfm_isqrt import hwfm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] operand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int CNT_W = $clog2(ROOT_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] v_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+1:0] rem_n;
	logic [ROOT_W+1:0] trial;
	logic              fits;

	// one digit step
	always_comb begin
		rem_n = {rem_q[ROOT_W-1:0], v_q[PROD_W-1 -: 2]};
		trial = {root_q, 2'b01};
		fits  = (rem_n >= trial);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[PROD_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_n - trial) : rem_n;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[rtl/hann_window_fft_magnitude.sv]
// ---------------------------------------------------------------------------
// hann_window_fft_magnitude
// Collects FFT_N samples, applies a Hann window, runs a radix-2 DIT FFT
// with growth bits and emits the FFT_N/2+1 bin magnitudes.
// ---------------------------------------------------------------------------
//  channel | signals                        | transfer
//  --------+--------------------------------+---------------------------
//  in      | in_valid in_stall sample       | in_valid  & !in_stall
//  out     | out_valid out_stall bin_index  | out_valid & !out_stall
//          | magnitude last_bin             |
//
// One sample per cycle while collecting; in_stall is high from the last
// sample of a block until the last bin has been loaded into the output.
// Per block: windowing, then the butterflies of every stage on the shared
// multiplier, then per bin two squares and the 24-step root; a bin waits
// while the output stalls. Reset is arst_n, asynchronous.
// ---------------------------------------------------------------------------
module hann_window_fft_magnitude import hwfm_pkg::*; #(
	parameter int FFT_N = FFT_N_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [BIN_W-1:0]              bin_index,
	output logic [MAG_W-1:0]              magnitude,
	output logic                          last_bin
);

	localparam int LOGN = $clog2(FFT_N);
	localparam int SW   = $clog2(LOGN);
	localparam int EW   = 2 * WORK_BITS;

	localparam logic [2:0] S_COLLECT = 3'd0;
	localparam logic [2:0] S_WIN     = 3'd1;
	localparam logic [2:0] S_BFLY    = 3'd2;
	localparam logic [2:0] S_MAG     = 3'd3;
	localparam logic [2:0] S_SQRT    = 3'd4;
	localparam logic [2:0] S_OUT     = 3'd5;

	// coefficient tables
	logic [WIN_W-1:0]       win_rom  [FFT_N];
	logic signed [TW_W-1:0] qsin_rom [17];

	for (genvar g = 0; g < FFT_N; g++) begin : g_win
		localparam int unsigned IP = (g < FFT_N - 1 - g) ? g : (FFT_N - 1 - g);
		localparam longint unsigned ANG = (PI_Q30 * IP) / (FFT_N - 1);
		assign win_rom[g] = win_coef(ANG);
	end

	for (genvar g = 0; g < 17; g++) begin : g_qsin
		localparam longint unsigned ANG = (PI_Q30 * g) / 32;
		assign qsin_rom[g] = qsin_coef(ANG);
	end

	function automatic logic [LOGN-1:0] bitrev(input logic [LOGN-1:0] v);
		logic [LOGN-1:0] r;
		for (int b = 0; b < LOGN; b++) begin
			r[LOGN-1-b] = v[b];
		end
		return r;
	endfunction

	function automatic logic [WORK_BITS-1:0] rnd15(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = (v + ACC_W'(1 << 14)) >>> 15;
		return t[WORK_BITS-1:0];
	endfunction

	// state
	logic [2:0]      state_q;
	logic [2:0]      ph_q;
	logic [LOGN:0]   fill_q;
	logic [LOGN-1:0] idx_q;
	logic [SW-1:0]   stage_q;

	// memories and read data
	logic [SAMPLE_BITS-1:0] sample_mem [FFT_N];
	logic [EW-1:0]          work_mem [FFT_N];
	logic [SAMPLE_BITS-1:0] smp_rd_q;
	logic [EW-1:0]          rd_a_q;
	logic [EW-1:0]          rd_b_q;

	logic signed [TW_W-1:0] sn_q;
	logic signed [TW_W-1:0] cs_q;
	logic [WORK_BITS-1:0]   tr_q;

	logic             out_valid_q;
	logic [BIN_W-1:0] bin_q;
	logic [MAG_W-1:0] mag_q;
	logic             last_q;

	// shared unit hookup
	logic signed [MUL_W-1:0]  mac_a;
	logic signed [MUL_W-1:0]  mac_b;
	logic [1:0]               acc_op;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     sqrt_start;
	logic                     sqrt_done;
	logic [ROOT_W-1:0]        root;

	logic                 in_xfer;
	logic                 out_free;
	logic                 smp_re;
	logic                 rd_en;
	logic                 wk_we;
	logic [LOGN-1:0]      wk_waddr;
	logic [EW-1:0]        wk_wdata;
	logic [LOGN-1:0]      rd_addr_a;
	logic [LOGN-1:0]      bf_a;
	logic [LOGN-1:0]      bf_b;
	logic [LOGN-1:0]      low_mask;
	logic [LOGN-1:0]      kk;
	logic [TW_LOG:0]      tw_m6;
	logic [TW_LOG-1:0]    tw_m;
	logic signed [TW_W-1:0] sn_n;
	logic signed [TW_W-1:0] cs_n;
	logic [WORK_BITS-1:0] xr;
	logic [WORK_BITS-1:0] xi;
	logic [WORK_BITS-1:0] ur;
	logic [WORK_BITS-1:0] ui;
	logic [WORK_BITS-1:0] ti;
	logic [WORK_BITS-1:0] ar;
	logic [WORK_BITS-1:0] ai;
	logic                 last_k;
	logic                 last_bin_n;

	assign in_stall  = (state_q != S_COLLECT);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign bin_index = bin_q;
	assign magnitude = mag_q;
	assign last_bin  = last_q;

	assign last_k     = (idx_q == LOGN'(FFT_N / 2 - 1));
	assign last_bin_n = (idx_q == LOGN'(FFT_N / 2));

	// butterfly addressing and twiddle selection
	always_comb begin
		kk       = {1'b0, idx_q[LOGN-2:0]};
		low_mask = LOGN'((1 << stage_q) - 1);
		bf_a     = LOGN'(((kk >> stage_q) << (stage_q + 1)) | (kk & low_mask));
		bf_b     = bf_a | LOGN'(1 << stage_q);
		tw_m6    = (TW_LOG + 1)'(kk & low_mask) << (TW_LOG - stage_q);
		tw_m     = tw_m6[TW_LOG-1:0];
		if (tw_m <= TW_LOG'(16)) begin
			sn_n = qsin_rom[tw_m];
			cs_n = qsin_rom[TW_LOG'(16) - tw_m];
		end else begin
			sn_n = qsin_rom[TW_LOG'(6'd32 - {1'b0, tw_m})];
			cs_n = -qsin_rom[tw_m - TW_LOG'(16)];
		end
	end

	// operand views of the work read data
	always_comb begin
		xr = rd_b_q[EW-1:WORK_BITS];
		xi = rd_b_q[WORK_BITS-1:0];
		ur = rd_a_q[EW-1:WORK_BITS];
		ui = rd_a_q[WORK_BITS-1:0];
		ti = rnd15(acc_q);
		ar = ur[WORK_BITS-1] ? (~ur + 1'b1) : ur;
		ai = ui[WORK_BITS-1] ? (~ui + 1'b1) : ui;
	end

	// sequencer outputs: operand select, memory controls
	always_comb begin
		mac_a      = '0;
		mac_b      = '0;
		acc_op     = ACC_HOLD;
		smp_re     = 1'b0;
		rd_en      = 1'b0;
		rd_addr_a  = (state_q == S_MAG) ? idx_q : bf_a;
		wk_we      = 1'b0;
		wk_waddr   = bf_a;
		wk_wdata   = '0;
		sqrt_start = 1'b0;
		unique case (state_q)
			S_WIN: begin
				unique case (ph_q)
					3'd0: smp_re = 1'b1;
					3'd1: begin
						mac_a = MUL_W'(signed'(smp_rd_q));
						mac_b = signed'(MUL_W'(win_rom[idx_q]));
					end
					3'd2: begin
						wk_we    = 1'b1;
						wk_waddr = bitrev(idx_q);
						wk_wdata = {rnd15(ACC_W'(prod_s1)), {WORK_BITS{1'b0}}};
					end
					default: ;
				endcase
			end
			S_BFLY: begin
				unique case (ph_q)
					3'd0: rd_en = 1'b1;
					3'd1: begin
						mac_a = MUL_W'(signed'(xr));
						mac_b = MUL_W'(cs_q);
					end
					3'd2: begin
						mac_a  = MUL_W'(signed'(xi));
						mac_b  = MUL_W'(sn_q);
						acc_op = ACC_LOAD;
					end
					3'd3: begin
						mac_a  = MUL_W'(signed'(xi));
						mac_b  = MUL_W'(cs_q);
						acc_op = ACC_ADD;
					end
					3'd4: begin
						mac_a  = MUL_W'(signed'(xr));
						mac_b  = MUL_W'(sn_q);
						acc_op = ACC_LOAD;
					end
					3'd5: acc_op = ACC_SUB;
					3'd6: begin
						wk_we    = 1'b1;
						wk_waddr = bf_a;
						wk_wdata = {ur + tr_q, ui + ti};
					end
					default: begin
						wk_we    = 1'b1;
						wk_waddr = bf_b;
						wk_wdata = {ur - tr_q, ui - ti};
					end
				endcase
			end
			S_MAG: begin
				unique case (ph_q)
					3'd0: rd_en = 1'b1;
					3'd1: begin
						mac_a = signed'({1'b0, ar});
						mac_b = signed'({1'b0, ar});
					end
					3'd2: begin
						mac_a  = signed'({1'b0, ai});
						mac_b  = signed'({1'b0, ai});
						acc_op = ACC_LOAD;
					end
					3'd3: acc_op = ACC_ADD;
					3'd4: sqrt_start = 1'b1;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// sample store
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_mem[fill_q[LOGN-1:0]] <= sample;
		end
		if (smp_re) begin
			smp_rd_q <= sample_mem[idx_q];
		end
	end

	// work store: one write port, two read ports
	always_ff @(posedge clk) begin
		if (wk_we) begin
			work_mem[wk_waddr] <= wk_wdata;
		end
		if (rd_en) begin
			rd_a_q <= work_mem[rd_addr_a];
			rd_b_q <= work_mem[bf_b];
		end
	end

	// twiddle and partial result registers
	always_ff @(posedge clk) begin
		if (state_q == S_BFLY && ph_q == 3'd0) begin
			sn_q <= sn_n;
			cs_q <= cs_n;
		end
		if (state_q == S_BFLY && ph_q == 3'd4) begin
			tr_q <= rnd15(acc_q);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLLECT;
			ph_q    <= '0;
			fill_q  <= '0;
			idx_q   <= '0;
			stage_q <= '0;
		end else begin
			unique case (state_q)
				S_COLLECT: begin
					if (in_xfer) begin
						if (fill_q == (LOGN + 1)'(FFT_N - 1)) begin
							fill_q  <= '0;
							state_q <= S_WIN;
							ph_q    <= '0;
							idx_q   <= '0;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				S_WIN: begin
					if (ph_q == 3'd2) begin
						ph_q <= '0;
						if (idx_q == LOGN'(FFT_N - 1)) begin
							idx_q   <= '0;
							stage_q <= '0;
							state_q <= S_BFLY;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				S_BFLY: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 3'd7) begin
						if (last_k) begin
							idx_q <= '0;
							if (stage_q == SW'(LOGN - 1)) begin
								state_q <= S_MAG;
							end else begin
								stage_q <= stage_q + 1'b1;
							end
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_MAG: begin
					if (ph_q == 3'd4) begin
						ph_q    <= '0;
						state_q <= S_SQRT;
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (last_bin_n) begin
							idx_q   <= '0;
							state_q <= S_COLLECT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_MAG;
						end
					end
				end
				default: state_q <= S_COLLECT;
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload, root saturated to the port width
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			bin_q  <= BIN_W'(idx_q);
			last_q <= last_bin_n;
			mag_q  <= (root[ROOT_W-1:MAG_W] != '0) ? {MAG_W{1'b1}} : root[MAG_W-1:0];
		end
	end

	hwfm_mac u_mac (
		.clk     (clk),
		.op_a    (mac_a),
		.op_b    (mac_b),
		.acc_op  (acc_op),
		.prod_s1 (prod_s1),
		.acc_q   (acc_q)
	);

	hwfm_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.operand (acc_q[PROD_W-1:0]),
		.done    (sqrt_done),
		.root    (root)
	);

endmodule
